FILE: src/first_fit_extent_allocator_macros.svh
// Assertion macros for the first-fit extent allocator.
// Included by first_fit_extent_allocator, which carries the concurrent assertions; no other dependencies.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define FFEA_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define FFEA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define FFEA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ffea_pkg.sv
// Shared constants, codes and structures for the first-fit extent allocator.
// No dependencies; used by ffea_cell and first_fit_extent_allocator.
package ffea_pkg;

    localparam int MAX_EXTENTS   = 16;
    localparam int OFFSET_BITS   = 20;
    localparam int LEN_BITS      = OFFSET_BITS + 1;
    localparam int STATUS_BITS   = 2;
    localparam int IN_DATA_BITS  = ((OFFSET_BITS + LEN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((OFFSET_BITS + 7) / 8) * 8;

    localparam logic [LEN_BITS-1:0] HEAP_RESET = LEN_BITS'(64'd1048576);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_BITS-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NO_SPACE   = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_TABLE_FULL = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ALLOC_TRIM,
        OP_ALLOC_REMOVE,
        OP_MERGE_PREV,
        OP_MERGE_NEXT,
        OP_MERGE_BOTH,
        OP_INSERT
    } t_op;

    typedef struct packed {
        logic                   valid;
        logic [OFFSET_BITS-1:0] start;
        logic [LEN_BITS-1:0]    len;
    } t_entry;

    // Operands of a newly accepted transaction, seen by every cell.
    typedef struct packed {
        logic                   en;
        logic [OFFSET_BITS-1:0] off;
        logic [LEN_BITS-1:0]    size;
    } t_eval;

    // Table update chosen by the control, applied by every cell.
    typedef struct packed {
        logic                   apply;
        t_op                    op;
        logic [OFFSET_BITS-1:0] off;
        logic [LEN_BITS-1:0]    size;
    } t_dec;

    // Per-cell findings reported to the control.
    typedef struct packed {
        logic prev_hit;
        logic next_hit;
        logic fit_hit;
        logic exact_hit;
    } t_cell_stat;

endpackage

FILE: src/first_fit_extent_allocator.sv
// First-fit extent allocator: an accepted transaction's operands and compare flags are registered,
// and the result register loads when its update commits in the apply state, which waits while an
// untaken result sits in the output register; no new transaction is taken until the last commits.
// In the apply state the first-fit and insert positions ripple along the row of 16 extent cells
// before every cell updates its entry at once. Reset (synchronous, active low) reloads one free
// extent [0, 1048576) and empties the result register; a heap_size write reloads [0, heap_size) in the same way.
module first_fit_extent_allocator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wen,
    input  logic [ffea_pkg::LEN_BITS-1:0]      i_cfg_wdata,      // heap_size
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [ffea_pkg::IN_DATA_BITS-1:0]  i_s_axis_tdata,   // offset, size, zero pad
    input  logic                               i_s_axis_tuser,   // command
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [ffea_pkg::OUT_DATA_BITS-1:0] o_m_axis_tdata,   // alloc_offset, zero pad
    output logic [ffea_pkg::STATUS_BITS-1:0]   o_m_axis_tuser    // status
);

    `include "first_fit_extent_allocator_macros.svh"

    localparam int NE = ffea_pkg::MAX_EXTENTS;
    localparam int OB = ffea_pkg::OFFSET_BITS;
    localparam int LB = ffea_pkg::LEN_BITS;

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } t_state;

    t_state                          r_state;
    logic                            r_cmd;
    logic [OB-1:0]                   r_off;
    logic [LB-1:0]                   r_size;
    logic                            r_m_valid;
    logic [OB-1:0]                   r_m_offset;
    logic [ffea_pkg::STATUS_BITS-1:0] r_m_status;

    logic                            w_accept;
    logic                            w_commit;
    logic                            w_load;
    ffea_pkg::t_entry                w_load_head;
    ffea_pkg::t_entry                w_zero_ent;
    ffea_pkg::t_eval                 w_eval;
    ffea_pkg::t_dec                  w_dec;
    logic [ffea_pkg::STATUS_BITS-1:0] w_status;
    logic [OB-1:0]                   w_alloc_off;

    ffea_pkg::t_entry                w_ent [NE];
    ffea_pkg::t_cell_stat            w_stat [NE];
    logic [NE:0]                     w_stop_chain;
    logic [NE:0]                     w_fit_chain;
    logic [NE:0]                     w_in_prefix;
    logic [NE-1:0]                   w_valid_vec;
    logic [NE-1:0]                   w_prev_vec;
    logic [NE-1:0]                   w_next_vec;
    logic [NE-1:0]                   w_fit_vec;
    logic [NE-1:0]                   w_exact_vec;

    // A transaction is taken only while no earlier one waits for its table update, and
    // never in reset or at a heap_size write, which both reload the table; a finished
    // result may still sit in the output register at that time.
    assign o_s_axis_tready = (r_state == S_IDLE) && i_rst_n && !i_cfg_wen;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_commit        = (r_state == S_APPLY) && (!r_m_valid || i_m_axis_tready);

    // Reset and heap_size writes both reload the table with a single extent at zero.
    assign w_load            = !i_rst_n || i_cfg_wen;
    assign w_zero_ent        = '0;
    assign w_load_head.start = '0;
    assign w_load_head.len   = i_rst_n ? i_cfg_wdata : ffea_pkg::HEAP_RESET;
    assign w_load_head.valid = (w_load_head.len != '0);

    assign w_eval.en   = w_accept;
    assign w_eval.off  = i_s_axis_tdata[OB-1:0];
    assign w_eval.size = i_s_axis_tdata[OB+LB-1:OB];

    // The chain of cells: prefix flags run from cell 0 upwards, the in-prefix flag comes
    // back from the right neighbour, and entries move one place left or right on update.
    assign w_stop_chain[0] = 1'b0;
    assign w_fit_chain[0]  = 1'b0;
    assign w_in_prefix[NE] = 1'b0;

    for (genvar g = 0; g < NE; g++) begin : g_cell
        ffea_cell u_cell (
            .i_clk             (i_clk),
            .i_load            (w_load),
            .i_load_ent        ((g == 0) ? w_load_head : w_zero_ent),
            .i_eval            (w_eval),
            .i_dec             (w_dec),
            .i_stop_before     (w_stop_chain[g]),
            .i_fit_before      (w_fit_chain[g]),
            .o_stop_after      (w_stop_chain[g+1]),
            .o_fit_after       (w_fit_chain[g+1]),
            .i_right_in_prefix (w_in_prefix[g+1]),
            .o_in_prefix       (w_in_prefix[g]),
            .i_left_ent        ((g == 0) ? w_zero_ent : w_ent[(g == 0) ? 0 : g - 1]),
            .i_right_ent       ((g == NE - 1) ? w_zero_ent : w_ent[(g == NE - 1) ? g : g + 1]),
            .o_ent             (w_ent[g]),
            .o_stat            (w_stat[g])
        );
        assign w_valid_vec[g] = w_ent[g].valid;
        assign w_prev_vec[g]  = w_stat[g].prev_hit;
        assign w_next_vec[g]  = w_stat[g].next_hit;
        assign w_fit_vec[g]   = w_stat[g].fit_hit;
        assign w_exact_vec[g] = w_stat[g].exact_hit;
    end

    // Only the first fitting cell raises its hit, so an OR of gated starts selects it.
    always_comb begin
        w_alloc_off = '0;
        for (int i = 0; i < NE; i++) begin
            w_alloc_off = w_alloc_off | (w_fit_vec[i] ? w_ent[i].start : '0);
        end
    end

    // Decide the update from the combined cell findings.
    always_comb begin
        w_dec.apply = w_commit;
        w_dec.off   = r_off;
        w_dec.size  = r_size;
        w_dec.op    = ffea_pkg::OP_NONE;
        w_status    = ffea_pkg::ST_OK;
        if (r_cmd == ffea_pkg::CMD_ALLOC) begin
            if (|w_fit_vec) begin
                w_dec.op = (|w_exact_vec) ? ffea_pkg::OP_ALLOC_REMOVE : ffea_pkg::OP_ALLOC_TRIM;
            end else begin
                w_status = ffea_pkg::ST_NO_SPACE;
            end
        end else if (r_size != '0) begin
            if ((|w_prev_vec) && (|w_next_vec)) begin
                w_dec.op = ffea_pkg::OP_MERGE_BOTH;
            end else if (|w_prev_vec) begin
                w_dec.op = ffea_pkg::OP_MERGE_PREV;
            end else if (|w_next_vec) begin
                w_dec.op = ffea_pkg::OP_MERGE_NEXT;
            end else if (w_valid_vec[NE-1]) begin
                // No neighbour to merge with and no free row: the free is dropped.
                w_status = ffea_pkg::ST_TABLE_FULL;
            end else begin
                w_dec.op = ffea_pkg::OP_INSERT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_commit) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_cmd  <= i_s_axis_tuser;
            r_off  <= w_eval.off;
            r_size <= w_eval.size;
        end
        if (w_commit) begin
            r_m_status <= w_status;
            r_m_offset <= ((r_cmd == ffea_pkg::CMD_ALLOC) && (|w_fit_vec)) ? w_alloc_off : '0;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {{(ffea_pkg::OUT_DATA_BITS - OB){1'b0}}, r_m_offset};
    assign o_m_axis_tuser  = r_m_status;

    // The valid entries stay packed at the low end of the row.
    `FFEA_ASSERT_ALWAYS(a_packed, i_clk, i_rst_n, (w_valid_vec & (w_valid_vec + 1'b1)) == '0, "extent table not packed")
    // At most one cell claims the first fit, the preceding or the following extent.
    `FFEA_ASSERT_ALWAYS(a_one_hit, i_clk, i_rst_n, $onehot0(w_fit_vec) && $onehot0(w_prev_vec) && $onehot0(w_next_vec), "more than one cell claims a role")
    // A committed update always leaves a result in the output register.
    `FFEA_ASSERT_NEXT(a_commit_out, i_clk, i_rst_n, w_commit, o_m_axis_tvalid, "result lost after update")
    // A failed transaction always carries a zero offset.
    `FFEA_ASSERT_SAME(a_zero_off, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser != ffea_pkg::ST_OK), r_m_offset == '0, "offset set on a failed transaction")
    // The status code is always one of the defined codes.
    `FFEA_ASSERT_SAME(a_status, i_clk, i_rst_n, o_m_axis_tvalid, (o_m_axis_tuser == ffea_pkg::ST_OK) || (o_m_axis_tuser == ffea_pkg::ST_NO_SPACE) || (o_m_axis_tuser == ffea_pkg::ST_TABLE_FULL), "undefined status code")

endmodule

FILE: src/ffea_cell.sv
// One extent cell of the allocator chain: holds one table entry and its compare flags.
// Depends on ffea_pkg; instantiated in a row by first_fit_extent_allocator.
module ffea_cell (
    input  logic                 i_clk,
    input  logic                 i_load,
    input  ffea_pkg::t_entry     i_load_ent,
    input  ffea_pkg::t_eval      i_eval,
    input  ffea_pkg::t_dec       i_dec,
    input  logic                 i_stop_before,
    input  logic                 i_fit_before,
    output logic                 o_stop_after,
    output logic                 o_fit_after,
    input  logic                 i_right_in_prefix,
    output logic                 o_in_prefix,
    input  ffea_pkg::t_entry     i_left_ent,
    input  ffea_pkg::t_entry     i_right_ent,
    output ffea_pkg::t_entry     o_ent,
    output ffea_pkg::t_cell_stat o_stat
);

    localparam int LB = ffea_pkg::LEN_BITS;
    localparam int OB = ffea_pkg::OFFSET_BITS;
    localparam logic [LB+1:0] LEN_MAX = {2'b00, {LB{1'b1}}};

    ffea_pkg::t_entry r_ent;
    ffea_pkg::t_entry n_ent;
    logic r_stop;
    logic r_fit;
    logic r_endeq;
    logic r_steq;
    logic r_exact;

    logic [LB:0]   w_end;
    logic [LB:0]   w_off_end;
    logic [LB+1:0] w_sum2;
    logic [LB+1:0] w_sum3;
    logic [LB-1:0] w_sat2;
    logic [LB-1:0] w_sat3;
    logic          w_is_prev;
    logic          w_is_nx;
    logic          w_is_next;
    logic          w_fit_hit;

    // Compare flags, taken against the operands as the transaction is accepted.
    assign w_end     = {1'b0, r_ent.start} + {1'b0, r_ent.len};
    assign w_off_end = {1'b0, i_eval.off} + {1'b0, i_eval.size};

    always_ff @(posedge i_clk) begin
        if (i_eval.en) begin
            r_stop  <= !r_ent.valid || !(r_ent.start < i_eval.off);
            r_fit   <= r_ent.valid && (r_ent.len >= i_eval.size);
            r_exact <= r_ent.len == i_eval.size;
            r_endeq <= r_ent.valid && (w_end == {2'b00, i_eval.off});
            r_steq  <= r_ent.valid && ({2'b00, r_ent.start} == w_off_end);
        end
    end

    // Position within the chain.
    assign o_in_prefix  = !i_stop_before && !r_stop;
    assign o_stop_after = i_stop_before || r_stop;
    assign o_fit_after  = i_fit_before || r_fit;
    assign w_is_prev    = o_in_prefix && !i_right_in_prefix;
    assign w_is_nx      = !i_stop_before && r_stop;
    assign w_is_next    = w_is_nx && r_ent.valid;
    assign w_fit_hit    = r_fit && !i_fit_before;

    assign o_stat.prev_hit  = w_is_prev && r_endeq;
    assign o_stat.next_hit  = w_is_next && r_steq;
    assign o_stat.fit_hit   = w_fit_hit;
    assign o_stat.exact_hit = w_fit_hit && r_exact;

    // Saturating merged lengths.
    assign w_sum2 = {2'b00, r_ent.len} + {2'b00, i_dec.size};
    assign w_sum3 = w_sum2 + {2'b00, i_right_ent.len};
    assign w_sat2 = (w_sum2 > LEN_MAX) ? {LB{1'b1}} : w_sum2[LB-1:0];
    assign w_sat3 = (w_sum3 > LEN_MAX) ? {LB{1'b1}} : w_sum3[LB-1:0];

    always_comb begin
        n_ent = r_ent;
        if (i_dec.apply) begin
            case (i_dec.op)
                ffea_pkg::OP_ALLOC_TRIM: begin
                    if (w_fit_hit) begin
                        n_ent.start = r_ent.start + i_dec.size[OB-1:0];
                        n_ent.len   = r_ent.len - i_dec.size;
                    end
                end
                ffea_pkg::OP_ALLOC_REMOVE: begin
                    if (o_fit_after) begin
                        n_ent = i_right_ent;
                    end
                end
                ffea_pkg::OP_MERGE_PREV: begin
                    if (w_is_prev) begin
                        n_ent.len = w_sat2;
                    end
                end
                ffea_pkg::OP_MERGE_NEXT: begin
                    if (w_is_next) begin
                        n_ent.start = i_dec.off;
                        n_ent.len   = w_sat2;
                    end
                end
                ffea_pkg::OP_MERGE_BOTH: begin
                    if (w_is_prev) begin
                        n_ent.len = w_sat3;
                    end else if (o_stop_after) begin
                        n_ent = i_right_ent;
                    end
                end
                ffea_pkg::OP_INSERT: begin
                    if (w_is_nx) begin
                        n_ent.valid = 1'b1;
                        n_ent.start = i_dec.off;
                        n_ent.len   = i_dec.size;
                    end else if (i_stop_before) begin
                        n_ent = i_left_ent;
                    end
                end
                default: begin
                    n_ent = r_ent;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ent <= i_load_ent;
        end else begin
            r_ent <= n_ent;
        end
    end

    assign o_ent = r_ent;

endmodule
